FILE: rtl/lkd_pkg.sv
`default_nettype none

package lkd_pkg;

	localparam int unsigned MAX_POSITIONS = 8;
	localparam int unsigned POS_W = 3;
	localparam int unsigned STEP_W = POS_W + 1;

	localparam logic [7:0] CMD_READ_KEYS   = 8'h42;
	localparam logic [7:0] CMD_DISPLAY_ON  = 8'h88;
	localparam logic [7:0] CMD_DISPLAY_OFF = 8'h80;
	localparam logic [7:0] ADDR_DIGIT_BASE = 8'hC0;
	localparam logic [7:0] ADDR_LED_BASE   = 8'hC1;

	typedef enum logic [2:0] {
		KIND_LEDS       = 3'd0,
		KIND_DIGITS     = 3'd1,
		KIND_BRIGHTNESS = 3'd2,
		KIND_SWITCH     = 3'd3,
		KIND_KEY_SCAN   = 3'd4
	} kind_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  small_value;
		logic [31:0] key_bytes;
		logic [4:0]  digit0;
		logic [4:0]  digit1;
		logic [4:0]  digit2;
		logic [4:0]  digit3;
		logic [4:0]  digit4;
		logic [4:0]  digit5;
		logic [4:0]  digit6;
		logic [4:0]  digit7;
	} item_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       frame_start;
		logic       frame_end;
		logic [3:0] key_code;
		logic       last;
	} result_t;

	function automatic logic [7:0] glyph_segments(input logic [4:0] idx);
		logic [7:0] seg;
		case (idx)
			5'd0:    seg = 8'h3F;
			5'd1:    seg = 8'h06;
			5'd2:    seg = 8'h5B;
			5'd3:    seg = 8'h4F;
			5'd4:    seg = 8'h66;
			5'd5:    seg = 8'h6D;
			5'd6:    seg = 8'h7D;
			5'd7:    seg = 8'h07;
			5'd8:    seg = 8'h7F;
			5'd9:    seg = 8'h6F;
			5'd10:   seg = 8'h77;
			5'd11:   seg = 8'h7C;
			5'd12:   seg = 8'h39;
			5'd13:   seg = 8'h5E;
			5'd14:   seg = 8'h79;
			5'd15:   seg = 8'h71;
			5'd16:   seg = 8'hBF;
			5'd17:   seg = 8'h86;
			5'd18:   seg = 8'hDB;
			5'd19:   seg = 8'hCF;
			5'd20:   seg = 8'hE6;
			5'd21:   seg = 8'hED;
			5'd22:   seg = 8'hFD;
			5'd23:   seg = 8'h87;
			5'd24:   seg = 8'hFF;
			5'd25:   seg = 8'hEF;
			5'd27:   seg = 8'h38;
			5'd28:   seg = 8'h76;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

	function automatic logic [3:0] decode_keys(input logic [31:0] bytes);
		logic [3:0] code;
		code = 4'd0;
		for (int i = 3; i >= 0; i--) begin
			if (bytes[8*i+4]) begin
				code = 4'(2*i + 2);
			end
			if (bytes[8*i]) begin
				code = 4'(2*i + 1);
			end
		end
		return code;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/led_key_display_frame_engine.sv
// Command sequencer for an 8-digit, 8-LED, 8-key display driver. An item is taken when start
// is high and busy is low. LED and digit items give 2*POSITIONS bytes, one per clock, as
// address and data pairs; brightness, switch and key scan items give one byte; kinds 5 to 7
// give nothing. Results leave one per cycle from the result register with result_valid high
// for exactly one cycle and cannot be held off, so the receiver must take every byte as it
// comes. An item is stored in in_s1 when it is taken, and its first byte is formed from there
// and then registered in result_s2. Busy drops in the cycle that the last byte is formed, so
// the next item follows with no gap; the step counter walks the single byte path one step per
// byte of the item.
`default_nettype none

module led_key_display_frame_engine #(
	parameter int unsigned POSITIONS = lkd_pkg::MAX_POSITIONS
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire lkd_pkg::item_t  cmd,
	output logic                 result_valid,
	output lkd_pkg::result_t     result
);

	localparam logic [lkd_pkg::POS_W-1:0] LAST_POS = lkd_pkg::POS_W'(POSITIONS - 1);

	lkd_pkg::item_t                in_s1;
	logic                          active_q;
	logic [lkd_pkg::STEP_W-1:0]    step_q;
	lkd_pkg::result_t              result_s2;
	logic                          result_valid_s2;

	lkd_pkg::result_t              res_d;
	logic                          last_d;
	logic                          accept;
	logic                          kind_ok;
	logic [lkd_pkg::POS_W-1:0]     pos;
	logic                          phase;
	logic [4:0]                    glyph_idx;

	assign pos   = step_q[lkd_pkg::STEP_W-1:1];
	assign phase = step_q[0];

	always_comb begin
		case (pos)
			3'd0:    glyph_idx = in_s1.digit0;
			3'd1:    glyph_idx = in_s1.digit1;
			3'd2:    glyph_idx = in_s1.digit2;
			3'd3:    glyph_idx = in_s1.digit3;
			3'd4:    glyph_idx = in_s1.digit4;
			3'd5:    glyph_idx = in_s1.digit5;
			3'd6:    glyph_idx = in_s1.digit6;
			default: glyph_idx = in_s1.digit7;
		endcase
	end

	always_comb begin
		res_d = '0;
		last_d = 1'b1;
		case (in_s1.kind)
			lkd_pkg::KIND_LEDS, lkd_pkg::KIND_DIGITS: begin
				last_d = phase && (pos == LAST_POS);
				res_d.last = last_d;
				res_d.frame_start = !phase;
				res_d.frame_end = phase;
				if (!phase) begin
					res_d.byte_out = ((in_s1.kind == lkd_pkg::KIND_LEDS) ?
						lkd_pkg::ADDR_LED_BASE : lkd_pkg::ADDR_DIGIT_BASE) +
						{4'd0, pos, 1'b0};
				end else if (in_s1.kind == lkd_pkg::KIND_LEDS) begin
					res_d.byte_out = {7'd0, in_s1.small_value[~pos]};
				end else begin
					res_d.byte_out = lkd_pkg::glyph_segments(glyph_idx);
				end
			end
			lkd_pkg::KIND_BRIGHTNESS: begin
				res_d.byte_out = lkd_pkg::CMD_DISPLAY_ON | {5'd0, in_s1.small_value[2:0]};
				res_d.frame_start = 1'b1;
				res_d.frame_end = 1'b1;
				res_d.last = 1'b1;
			end
			lkd_pkg::KIND_SWITCH: begin
				res_d.byte_out = (in_s1.small_value != 8'd0) ?
					lkd_pkg::CMD_DISPLAY_ON : lkd_pkg::CMD_DISPLAY_OFF;
				res_d.frame_start = 1'b1;
				res_d.frame_end = 1'b1;
				res_d.last = 1'b1;
			end
			lkd_pkg::KIND_KEY_SCAN: begin
				res_d.byte_out = lkd_pkg::CMD_READ_KEYS;
				res_d.frame_start = 1'b1;
				res_d.frame_end = 1'b1;
				res_d.key_code = lkd_pkg::decode_keys(in_s1.key_bytes);
				res_d.last = 1'b1;
			end
			default: begin
				res_d = '0;
				last_d = 1'b1;
			end
		endcase
	end

	assign busy    = active_q && !last_d;
	assign accept  = start && !busy;
	assign kind_ok = cmd.kind inside {[lkd_pkg::KIND_LEDS:lkd_pkg::KIND_KEY_SCAN]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q <= '0;
			result_valid_s2 <= 1'b0;
		end else begin
			result_valid_s2 <= active_q;
			if (accept) begin
				active_q <= kind_ok;
				step_q <= '0;
			end else if (active_q) begin
				step_q <= step_q + 1'b1;
				if (last_d) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_s1 <= cmd;
		end
		result_s2 <= res_d;
	end

	assign result       = result_s2;
	assign result_valid = result_valid_s2;

	a_results_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |=> result_valid)
		else $error("A result item is missing between the first and last of an item.");

	a_first_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.kind == lkd_pkg::KIND_LEDS || cmd.kind == lkd_pkg::KIND_DIGITS ||
		cmd.kind == lkd_pkg::KIND_BRIGHTNESS || cmd.kind == lkd_pkg::KIND_SWITCH ||
		cmd.kind == lkd_pkg::KIND_KEY_SCAN) |-> ##2 result_valid)
		else $error("An accepted item did not produce its first result.");

	a_key_code_scan_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.key_code != 4'd0 |->
		result.byte_out == lkd_pkg::CMD_READ_KEYS && result.last)
		else $error("A key code appeared on a result that is not a key scan.");

endmodule

`default_nettype wire
